// ===== hw/rtl/fl16_pkg.sv =====
// Package for the Fletcher-16 checksum unit: word types, op codes, seeds and
// the modulo-255 reduction used by the sum core.
// No dependencies.
package fl16_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned OP_W   = 2;

	localparam logic [BYTE_W-1:0] SEED_A = 8'hAA;
	localparam logic [BYTE_W-1:0] SEED_B = 8'h00;
	localparam logic [BYTE_W:0]   MOD_F  = 9'd255;

	typedef enum logic [OP_W-1:0] {
		OP_ACCUM    = 2'd0,
		OP_GENERATE = 2'd1,
		OP_VERIFY   = 2'd2
	} op_t;

	typedef enum logic {
		KIND_CHECK   = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	// One input word as held in the input register.
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] data_byte;
	} in_word_t;

	// One result word as held in the output register.
	typedef struct packed {
		logic              result_kind;
		logic [BYTE_W-1:0] check_first;
		logic [BYTE_W-1:0] check_second;
		logic              frame_ok;
	} res_word_t;

	// Reduce a sum of two values below 255 and 256 (so below 510) mod 255.
	function automatic logic [BYTE_W-1:0] mod255(input logic [BYTE_W:0] s);
		logic [BYTE_W:0] d;
		d = s - MOD_F;
		return (s >= MOD_F) ? d[BYTE_W-1:0] : s[BYTE_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/fl16_in_stage.sv =====
// Input register of the Fletcher-16 checksum unit: holds one accepted word
// until the sum core consumes it. Depends on fl16_pkg.
module fl16_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  fl16_pkg::in_word_t in_word,
	input  logic             advance,
	output logic             valid_s1,
	output fl16_pkg::in_word_t word_s1
);
	import fl16_pkg::*;

	// The register can take a word when empty or when its word moves on.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

endmodule

// ===== hw/rtl/fl16_sum_core.sv =====
// Running modulo-255 sums and check-byte / verdict logic of the Fletcher-16
// checksum unit. Depends on fl16_pkg.
module fl16_sum_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  fl16_pkg::in_word_t word_s1,
	output logic               res_valid,
	output fl16_pkg::res_word_t res_word
);
	import fl16_pkg::*;

	logic [BYTE_W-1:0] sum_a_q;
	logic [BYTE_W-1:0] sum_b_q;
	logic [BYTE_W-1:0] a_new;
	logic [BYTE_W-1:0] b_new;
	logic [BYTE_W-1:0] first;
	logic [BYTE_W-1:0] second;
	logic              is_gen;
	logic              is_ver;

	// Fold the byte in, then derive the check bytes from the updated sums.
	always_comb begin
		a_new  = mod255({1'b0, sum_a_q} + {1'b0, word_s1.data_byte});
		b_new  = mod255({1'b0, sum_b_q} + {1'b0, a_new});
		first  = BYTE_W'(MOD_F - {1'b0, mod255({1'b0, a_new} + {1'b0, b_new})});
		second = BYTE_W'(MOD_F - {1'b0, mod255({1'b0, a_new} + {1'b0, first})});
		is_gen = 1'b0;
		is_ver = 1'b0;
		case (op_t'(word_s1.op))
			OP_GENERATE: is_gen = 1'b1;
			OP_VERIFY:   is_ver = 1'b1;
			default: begin
				is_gen = 1'b0;
				is_ver = 1'b0;
			end
		endcase
	end

	always_comb begin
		res_valid             = fire && (is_gen || is_ver);
		res_word.result_kind  = is_ver ? KIND_VERDICT : KIND_CHECK;
		res_word.check_first  = is_gen ? first  : '0;
		res_word.check_second = is_gen ? second : '0;
		res_word.frame_ok     = is_ver && (a_new == '0) && (b_new == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q <= SEED_A;
			sum_b_q <= SEED_B;
		end else if (fire) begin
			if (is_gen || is_ver) begin
				sum_a_q <= SEED_A;
				sum_b_q <= SEED_B;
			end else begin
				sum_a_q <= a_new;
				sum_b_q <= b_new;
			end
		end
	end

	a_sums_reseed: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (is_gen || is_ver) |=> (sum_a_q == SEED_A) && (sum_b_q == SEED_B))
		else $error("sums not reseeded after end of frame");

	a_sums_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_a_q != 8'hFF) && (sum_b_q != 8'hFF))
		else $error("running sum left the modulo-255 range");

endmodule

// ===== hw/rtl/fl16_out_stage.sv =====
// Output register of the Fletcher-16 checksum unit: holds one result word
// until the receiver takes it. Depends on fl16_pkg.
module fl16_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  fl16_pkg::res_word_t res_word,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output fl16_pkg::res_word_t out_word
);
	import fl16_pkg::*;

	logic      out_valid_q;
	res_word_t out_word_q;

	// Free when empty or when the held word is taken in this cycle.
	assign free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (free) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			out_word_q <= res_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !load)
		else $error("result loaded over a word still waiting");

endmodule

// ===== hw/rtl/fletcher16_mod255_checksum_unit.sv =====
// Top level of the byte-serial Fletcher-16 checksum unit (modulo-255 sums).
// Instantiates fl16_in_stage, fl16_sum_core and fl16_out_stage; uses fl16_pkg.
//
// Usage:
//   The slave channel takes one word per frame byte: s_tdata carries the byte,
//   s_tuser the op. Op accumulate folds the byte into the running sums. Op
//   generate folds the byte as the last payload byte and then returns a word
//   with the two check bytes. Op verify folds the byte as the last byte of a
//   received frame (its second check byte) and returns a verdict word whose
//   frame_ok is set when both sums end at zero. The unused op code folds the
//   byte like accumulate. After a generate or verify word the sums go back to
//   their seeds (sum A 0xAA, sum B zero). Only generate and verify words
//   produce a master-side word; m_tuser says which kind it is.
//   An accepted word waits in the input register and its result word in the
//   output register, which drives m_tvalid. Throughput: one word per cycle
//   while results are taken; the sums update with a short modulo-255 add chain.
//   Reset (arst_n low) empties both registers and reseeds the sums.
//   When the receiver holds m_tready low with a result waiting, the input
//   register stops advancing and s_tready falls once it is full; no word is
//   lost and the sums do not move until the receiver takes the waiting word.
module fletcher16_mod255_checksum_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] check_first, [15:8] check_second, [16] frame_ok
	output logic [0:0]  m_tuser    // [0] result_kind
);
	import fl16_pkg::*;

	in_word_t  in_word;
	in_word_t  word_s1;
	res_word_t res_word;
	res_word_t out_word;
	logic      valid_s1;
	logic      out_free;
	logic      fire;
	logic      res_valid;

	assign in_word.op        = s_tuser;
	assign in_word.data_byte = s_tdata;

	// The word in the input register is consumed whenever the output register
	// can take whatever it produces.
	assign fire = valid_s1 && out_free;

	fl16_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_word  (in_word),
		.advance  (out_free),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	fl16_sum_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.word_s1   (word_s1),
		.res_valid (res_valid),
		.res_word  (res_word)
	);

	fl16_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res_word  (res_word),
		.free      (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (out_word)
	);

	// Pack the result: check bytes low, verdict flag above, zero fill to 24 bits.
	assign m_tdata = {7'd0, out_word.frame_ok, out_word.check_second, out_word.check_first};
	assign m_tuser = out_word.result_kind;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid && !m_tready)
		else $error("input stalled without a stalled result");

endmodule
